>>> rtl/base64_encoder_unit_assert.svh
`ifndef BASE64_ENCODER_UNIT_ASSERT_SVH
`define BASE64_ENCODER_UNIT_ASSERT_SVH

// Property checked at every rising clock edge, suspended while reset is asserted.
`define B64E_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define B64E_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/b64e_pkg.sv
package b64e_pkg;

    localparam int unsigned B64E_QUEUE_DEPTH = 2;
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_THIRD  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            last;
    } t_job;

    function automatic logic [7:0] b64_sym(input logic [5:0] six);
        logic [7:0] v;
        v = {2'b00, six};
        if (six < 6'd26) begin
            b64_sym = v + 8'd65;
        end else if (six < 6'd52) begin
            b64_sym = v + 8'd71;
        end else if (six < 6'd62) begin
            b64_sym = v - 8'd4;
        end else if (six == 6'd62) begin
            b64_sym = 8'h2B;
        end else begin
            b64_sym = 8'h2F;
        end
    endfunction

endpackage

>>> rtl/b64e_front.sv
module b64e_front
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_data,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [3:0] r_left;
    logic [3:0] n_left;

    assign o_push = i_valid && !i_full;

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        if (o_push) begin
            unique case (r_phase)
                PHASE_SECOND: begin
                    n_phase = PHASE_THIRD;
                    n_left  = i_data_byte[3:0];
                end
                PHASE_THIRD: begin
                    n_phase = PHASE_FIRST;
                    n_left  = 4'd0;
                end
                default: begin
                    n_phase = PHASE_SECOND;
                    n_left  = {2'b00, i_data_byte[1:0]};
                end
            endcase
            if (i_end_of_data) begin
                n_phase = PHASE_FIRST;
                n_left  = 4'd0;
            end
        end
    end

    always_comb begin
        o_job.chars    = {4{PAD_CHAR}};
        o_job.last     = i_end_of_data;
        o_job.last_idx = 2'd0;
        unique case (r_phase)
            PHASE_SECOND: begin
                o_job.chars[0] = b64_sym({r_left[1:0], i_data_byte[7:4]});
                o_job.chars[1] = b64_sym({i_data_byte[3:0], 2'b00});
                if (i_end_of_data) begin
                    o_job.last_idx = 2'd2;
                end
            end
            PHASE_THIRD: begin
                o_job.chars[0] = b64_sym({r_left, i_data_byte[7:6]});
                o_job.chars[1] = b64_sym(i_data_byte[5:0]);
                o_job.last_idx = 2'd1;
            end
            default: begin
                o_job.chars[0] = b64_sym(i_data_byte[7:2]);
                o_job.chars[1] = b64_sym({i_data_byte[1:0], 4'b0000});
                if (i_end_of_data) begin
                    o_job.last_idx = 2'd3;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_FIRST;
            r_left  <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

>>> rtl/b64e_queue.sv
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int unsigned DEPTH = B64E_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [AW:0]   n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (AW + 1)'(DEPTH));
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> rtl/b64e_back.sv
module b64e_back
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_job,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic [1:0] r_idx;
    logic       n_valid;
    logic [1:0] n_idx;
    logic       load;
    logic       take;
    logic       job_done;

    assign load     = !r_valid || !i_stall;
    assign take     = load && !i_empty;
    assign job_done = (r_idx == i_job.last_idx);
    assign o_pop    = take && job_done;

    always_comb begin
        n_valid = load ? !i_empty : r_valid;
        n_idx   = r_idx;
        if (take) begin
            n_idx = job_done ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_char <= i_job.chars[r_idx];
            r_last <= i_job.last && job_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule

>>> rtl/base64_encoder_unit.sv
// Streaming base64 encoder with the standard alphabet and '=' padding.
// Input channel: i_valid, o_stall, i_data_byte, i_end_of_data. A byte is taken
// at a clock edge with i_valid high and o_stall low. i_end_of_data marks the
// final byte of a message and flushes the partial group with its padding.
// Output channel: o_valid, i_stall, o_out_char, o_last_char. One ASCII character
// is delivered per accepted edge, and o_last_char flags the final character.
// Each byte turns into one to four characters held in a small queue. The
// first character of a byte passes through the queue and then the output
// register. The output register sends one character per cycle while the
// receiver does not stall, so the block sustains four characters for every
// three bytes. Bytes are taken every cycle until the queue of QUEUE_DEPTH
// entries fills.
// When the receiver stalls, the held character stays unchanged and the queue
// keeps accepting bytes until it is full, then o_stall rises.
// Reset clears the group position, the queue, and the output valid flag and
// character index, so o_valid and o_stall are low after reset.
module base64_encoder_unit
    import b64e_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = B64E_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);

    t_job front_job;
    t_job head_job;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    assign o_stall = q_full;

    b64e_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_data_byte   (i_data_byte),
        .i_end_of_data (i_end_of_data),
        .i_full        (q_full),
        .o_push        (push),
        .o_job         (front_job)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

>>> rtl/b64e_checker.sv
`include "base64_encoder_unit_assert.svh"

module b64e_checker
    import b64e_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_char,
    input logic       o_last_char
);

    // Reset empties both channels.
    `B64E_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid && !o_stall, "not idle after reset")

    // A stalled character is held unchanged.
    `B64E_ASSERT(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_out_char) && $stable(o_last_char), "stalled character changed")

    // A pad that is not final is followed at once by the final pad.
    `B64E_ASSERT(a_pad_pair, i_clk, i_rst_n, o_valid && !i_stall && o_out_char == PAD_CHAR && !o_last_char |=> o_valid && o_out_char == PAD_CHAR && o_last_char, "first pad not followed by final pad")

    // The character right after the final character of a message is never a pad.
    `B64E_ASSERT(a_pad_end, i_clk, i_rst_n, o_valid && !i_stall && o_last_char |=> !o_valid || o_out_char != PAD_CHAR, "pad after end of message")

endmodule

bind base64_encoder_unit b64e_checker u_b64e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_char  (o_out_char),
    .o_last_char (o_last_char)
);
